// ===== sv/hbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Huffman bit packer package
// Shared widths, command codes and the code table access types.
// ----------------------------------------------------------------------------
package hbp_pkg;

   localparam int MAX_CODE_LEN_DEFAULT = 32;
   localparam int SYMBOL_COUNT_DEFAULT = 256;

   localparam int CMD_WIDTH    = 2;
   localparam int SYM_WIDTH    = 8;
   localparam int CODE_WIDTH   = 32;
   localparam int LEN_WIDTH    = 6;
   localparam int BYTE_WIDTH   = 8;
   localparam int MAX_BURST    = 4;
   localparam int BURST_CNT_W  = 3;
   localparam int PACK_CNT_W   = 3;
   localparam int WINDOW_WIDTH = CODE_WIDTH + BYTE_WIDTH;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [SYM_WIDTH-1:0]  symbol;
      logic [CODE_WIDTH-1:0] code;
      logic [LEN_WIDTH-1:0]  length;
   } tbl_req_type;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] code;
      logic [LEN_WIDTH-1:0]  length;
   } tbl_rsp_type;

endpackage

// ===== sv/hbp_req_if.sv =====
// ----------------------------------------------------------------------------
// Huffman bit packer request channel
// Valid/ready channel carrying load, encode and flush commands.
// ----------------------------------------------------------------------------
interface hbp_req_if;

   logic                              valid;
   logic                              ready;
   logic [hbp_pkg::CMD_WIDTH-1:0]     command;
   logic [hbp_pkg::SYM_WIDTH-1:0]     symbol;
   logic [hbp_pkg::CODE_WIDTH-1:0]    code_bits;
   logic [hbp_pkg::LEN_WIDTH-1:0]     code_length;

   modport source (output valid, command, symbol, code_bits, code_length, input ready);
   modport sink   (input valid, command, symbol, code_bits, code_length, output ready);

endinterface

// ===== sv/hbp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Huffman bit packer response channel
// Valid/ready channel carrying packed output bytes.
// ----------------------------------------------------------------------------
interface hbp_rsp_if;

   logic                              valid;
   logic                              ready;
   logic [hbp_pkg::BYTE_WIDTH-1:0]    out_byte;
   logic                              last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);

endinterface

// ===== sv/hbp_code_table.sv =====
// ----------------------------------------------------------------------------
// Huffman bit packer code table
// Single-port code/length memory with a registered read and per-entry valid
// bits, so that entries never loaded read as a zero-length code.
// ----------------------------------------------------------------------------
module hbp_code_table #(
   parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEFAULT,
   parameter int CODE_W       = hbp_pkg::CODE_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hbp_pkg::tbl_req_type tbl_req,
   output hbp_pkg::tbl_rsp_type tbl_rsp
);

   localparam int ADDR_W = $clog2(SYMBOL_COUNT);

   logic [CODE_W-1:0]             code_mem [SYMBOL_COUNT];
   logic [hbp_pkg::LEN_WIDTH-1:0] len_mem  [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0]       valid_ff;

   logic                          hit_ff;
   logic [CODE_W-1:0]             code_ff;
   logic [hbp_pkg::LEN_WIDTH-1:0] len_ff;
   logic [ADDR_W-1:0]             addr;

   assign addr = tbl_req.symbol[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         code_mem[addr] <= tbl_req.code[CODE_W-1:0];
         len_mem[addr]  <= tbl_req.length;
      end
      if (tbl_req.rd_en) begin
         code_ff <= code_mem[addr];
         len_ff  <= len_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (tbl_req.wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
         if (tbl_req.rd_en) begin
            hit_ff <= valid_ff[addr];
         end
      end
   end

   // An entry that was never loaded behaves as an empty code.
   assign tbl_rsp.code   = hit_ff ? hbp_pkg::CODE_WIDTH'(code_ff) : '0;
   assign tbl_rsp.length = hit_ff ? len_ff : '0;

endmodule

// ===== sv/huffman_table_bit_packer.sv =====
// ----------------------------------------------------------------------------
// Huffman table bit packer
// Table-driven Huffman encoder: loads code table entries, encodes symbols
// into an MSB-first bit stream and emits whole bytes, with a flush command
// that pads and emits the final partial byte.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Transaction carries
//   req_ch    in          command, symbol, code_bits, code_length
//   rsp_ch    out         out_byte, last
//
// An encode reads the table at its accepting edge and enters the packer stage
// in the next cycle; its bytes leave through the burst register. Items that
// complete no byte pass at one per cycle. The burst register sends one byte
// per cycle while rsp_ch is ready, so items that produce bytes follow no faster
// than their bytes (up to four per item) leave. Reset clears the table valid
// bits. A stall on rsp_ch holds the burst, then the packer, then req_ch.ready.
//
module huffman_table_bit_packer #(
   parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEFAULT,
   parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   hbp_req_if.sink   req_ch,
   hbp_rsp_if.source rsp_ch
);

   // Stored code width: the table never keeps more bits than a code can have.
   localparam int CODE_W = (MAX_CODE_LEN < hbp_pkg::CODE_WIDTH) ?
                           MAX_CODE_LEN : hbp_pkg::CODE_WIDTH;
   localparam int CW  = hbp_pkg::CODE_WIDTH;
   localparam int LW  = hbp_pkg::LEN_WIDTH;
   localparam int BW  = hbp_pkg::BYTE_WIDTH;
   localparam int WW  = hbp_pkg::WINDOW_WIDTH;
   localparam int BCW = hbp_pkg::BURST_CNT_W;
   localparam int PCW = hbp_pkg::PACK_CNT_W;

   // ------------------------------------------------------------------------
   // Request decode and table access
   // ------------------------------------------------------------------------
   logic                 req_fire;
   logic                 in_range;
   logic                 is_load;
   logic                 is_encode;
   logic                 is_flush;
   logic [LW-1:0]        len_clamp;
   logic [CW-1:0]        code_mask;
   hbp_pkg::tbl_req_type tbl_req;
   hbp_pkg::tbl_rsp_type tbl_rsp;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign in_range  = {1'b0, req_ch.symbol} < (hbp_pkg::SYM_WIDTH + 1)'(SYMBOL_COUNT);
   assign is_load   = req_ch.command == hbp_pkg::CMD_LOAD;
   assign is_encode = req_ch.command == hbp_pkg::CMD_ENCODE;
   assign is_flush  = req_ch.command == hbp_pkg::CMD_FLUSH;

   // Lengths beyond the table width are clamped, and code bits above the
   // stored length are dropped.
   assign len_clamp = (req_ch.code_length > LW'(CODE_W)) ? LW'(CODE_W) : req_ch.code_length;
   assign code_mask = (len_clamp >= LW'(CW)) ? {CW{1'b1}} : ~({CW{1'b1}} << len_clamp);

   always_comb begin
      tbl_req.wr_en  = req_fire && is_load && in_range;
      tbl_req.rd_en  = req_fire && is_encode && in_range;
      tbl_req.symbol = req_ch.symbol;
      tbl_req.code   = req_ch.code_bits & code_mask;
      tbl_req.length = len_clamp;
   end

   hbp_code_table #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .CODE_W       (CODE_W)
   ) u_code_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

   // ------------------------------------------------------------------------
   // Packer stage. The table read data lines up with this stage, so the
   // packer works on the code in the cycle after the request was accepted.
   // ------------------------------------------------------------------------
   logic          s2_valid_ff;
   logic          s2_encode_ff;
   logic          s2_flush_ff;
   logic          s2_needs_burst;
   logic          s2_advance;

   logic [BW-1:0]  pend_ff;
   logic [BW-1:0]  pend_in;
   logic [PCW-1:0] pcnt_ff;
   logic [PCW-1:0] pcnt_in;

   logic [CW-1:0]  code_aligned;
   logic [WW-1:0]  window;
   logic [LW-1:0]  total_bits;
   logic [BCW-1:0] full_bytes;

   logic [BCW-1:0] bcnt_ff;
   logic [BCW-1:0] bcnt_in;
   logic [CW-1:0]  bdata_ff;
   logic [CW-1:0]  bdata_in;
   logic           burst_free;

   // Left-align the code, then place it right after the pending bits.
   assign code_aligned = tbl_rsp.code << (LW'(CW) - tbl_rsp.length);
   assign window       = {pend_ff, {CW{1'b0}}} | ({code_aligned, {BW{1'b0}}} >> pcnt_ff);
   assign total_bits   = LW'(pcnt_ff) + tbl_rsp.length;
   assign full_bytes   = total_bits[LW-1:3];

   assign s2_needs_burst = (s2_encode_ff && (full_bytes != '0)) ||
                           (s2_flush_ff && (pcnt_ff != '0));

   // The burst register can take a new set of bytes when it is empty or its
   // last byte leaves in this cycle.
   assign burst_free = (bcnt_ff == '0) || ((bcnt_ff == BCW'(1)) && rsp_ch.ready);
   assign s2_advance = s2_valid_ff && (!s2_needs_burst || burst_free);

   assign req_ch.ready = !s2_valid_ff || s2_advance;

   always_comb begin
      pend_in = pend_ff;
      pcnt_in = pcnt_ff;
      if (s2_advance && s2_encode_ff) begin
         pcnt_in = total_bits[PCW-1:0];
         case (full_bytes)
            3'd0:    pend_in = window[WW-1      -: BW];
            3'd1:    pend_in = window[WW-1-BW   -: BW];
            3'd2:    pend_in = window[WW-1-2*BW -: BW];
            3'd3:    pend_in = window[WW-1-3*BW -: BW];
            3'd4:    pend_in = window[WW-1-4*BW -: BW];
            default: pend_in = '0;
         endcase
      end else if (s2_advance && s2_flush_ff) begin
         pend_in = '0;
         pcnt_in = '0;
      end
   end

   // ------------------------------------------------------------------------
   // Output burst register: holds up to four finished bytes and shifts them
   // out, earliest byte first. It also serves as the response register.
   // ------------------------------------------------------------------------
   always_comb begin
      bcnt_in  = bcnt_ff;
      bdata_in = bdata_ff;
      if (s2_advance && s2_needs_burst) begin
         if (s2_flush_ff) begin
            bcnt_in  = BCW'(1);
            bdata_in = {pend_ff, {(CW-BW){1'b0}}};
         end else begin
            bcnt_in  = full_bytes;
            bdata_in = window[WW-1 -: CW];
         end
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         bcnt_in  = bcnt_ff - BCW'(1);
         bdata_in = bdata_ff << BW;
      end
   end

   assign rsp_ch.valid    = bcnt_ff != '0;
   assign rsp_ch.out_byte = bdata_ff[CW-1 -: BW];
   assign rsp_ch.last     = bcnt_ff == BCW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s2_encode_ff <= 1'b0;
         s2_flush_ff  <= 1'b0;
         pend_ff      <= '0;
         pcnt_ff      <= '0;
         bcnt_ff      <= '0;
      end else begin
         if (req_ch.ready) begin
            s2_valid_ff  <= req_fire && ((is_encode && in_range) || is_flush);
            s2_encode_ff <= req_fire && is_encode && in_range;
            s2_flush_ff  <= req_fire && is_flush;
         end
         pend_ff <= pend_in;
         pcnt_ff <= pcnt_in;
         bcnt_ff <= bcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bdata_ff <= bdata_in;
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      bcnt_ff <= BCW'(hbp_pkg::MAX_BURST))
      else $error("burst count exceeds four bytes");

   a_empty_pending: assert property (@(posedge clock) disable iff (reset)
      (pcnt_ff == '0) |-> (pend_ff == '0))
      else $error("empty packer holds stray bits");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_advance) |-> !req_ch.ready)
      else $error("request accepted while packer stage is stalled");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_advance) |=> (s2_valid_ff && $stable(s2_flush_ff) &&
                                        $stable(s2_encode_ff) && $stable(pcnt_ff)))
      else $error("stalled packer item was lost or changed");

endmodule

// ===== bench/huffman_table_bit_packer_tb.sv =====
// ----------------------------------------------------------------------------
// Huffman table bit packer testbench
// Loads code table entries, encodes symbols and flushes the packer through
// the request channel, and predicts every packed byte from a shadow copy of
// the code table and the packer. Each byte on the response channel is checked
// in order against the prediction, with random idling on both channels.
// ----------------------------------------------------------------------------
module huffman_table_bit_packer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CMD_W  = hbp_pkg::CMD_WIDTH;
   localparam int SYM_W  = hbp_pkg::SYM_WIDTH;
   localparam int CODE_W = hbp_pkg::CODE_WIDTH;
   localparam int LEN_W  = hbp_pkg::LEN_WIDTH;
   localparam int BYTE_W = hbp_pkg::BYTE_WIDTH;

   // The command field is two bits wide, but only three codes have a meaning.
   // The fourth one must be ignored by the block, so it is driven as well.
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   localparam int TABLE_DEPTH       = 256;
   localparam int RESET_CYCLES      = 12;
   localparam int RANDOM_ITEMS      = 250;
   localparam int HOLD_OFF_CYCLES   = 200;
   localparam int DRAIN_TAIL_CYCLES = 16;
   localparam int CYCLE_LIMIT       = 200000;

   // One byte that the packer is predicted to emit.
   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } packed_byte_type;

   // Receiver stall patterns. The receiver switches between them at random.
   typedef enum int {
      RX_ALWAYS,
      RX_COIN,
      RX_PERIODIC,
      RX_SPARSE
   } rx_pattern_type;

   logic clock;
   logic reset;

   hbp_req_if req_if();
   hbp_rsp_if rsp_if();

   huffman_table_bit_packer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Shadow copy of the code table and the packer state.
   logic [CODE_W-1:0] shadow_code [TABLE_DEPTH];
   logic [LEN_W-1:0]  shadow_len  [TABLE_DEPTH];
   logic [BYTE_W-1:0] shadow_byte;
   logic [2:0]        shadow_free_pos;

   // Bytes that have been predicted but not yet seen on the response channel.
   packed_byte_type packed_bytes_due[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   // Sender burst control.
   int unsigned burst_left;
   bit          sender_gaps_on;

   // Receiver control. The test bumps hold_off_count; the receiver process
   // notices the change and turns it into a counted stretch of stalled cycles.
   int unsigned    hold_off_count  = 0;
   int unsigned    hold_off_taken  = 0;
   int unsigned    hold_off_left   = 0;
   rx_pattern_type rx_pattern      = RX_ALWAYS;
   int unsigned    rx_pattern_left = 0;
   int unsigned    rx_phase        = 0;

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Applies one accepted request transaction to the shadow state and queues
   // the bytes that it completes. An encode marks its final byte as last; a
   // flush emits the partial byte, zero padded, only if any bit is pending.
   function automatic void pack_into_bytes(input logic [CMD_W-1:0]  cmd,
                                           input logic [SYM_W-1:0]  sym,
                                           input logic [CODE_W-1:0] bits,
                                           input logic [LEN_W-1:0]  len);
      int                n;
      int                emitted;
      logic [CODE_W-1:0] code;
      packed_byte_type   pb;

      emitted = 0;
      case (cmd)
         hbp_pkg::CMD_LOAD: begin
            // Long lengths are clipped to the table width and the code bits
            // above the stored length are dropped.
            n = int'(len);
            if (n > CODE_W) begin
               n = CODE_W;
            end
            code = bits;
            if (n < CODE_W) begin
               code = bits & ((32'h1 << n) - 32'h1);
            end
            shadow_code[sym] = code;
            shadow_len[sym]  = LEN_W'(n);
         end
         hbp_pkg::CMD_ENCODE: begin
            n    = int'(shadow_len[sym]);
            code = shadow_code[sym];
            for (int i = 0; i < n; i++) begin
               shadow_byte[shadow_free_pos] = code[n - 1 - i];
               if (shadow_free_pos == 3'd0) begin
                  pb.out_byte = shadow_byte;
                  pb.last     = 1'b0;
                  packed_bytes_due.push_back(pb);
                  emitted++;
                  shadow_byte     = '0;
                  shadow_free_pos = 3'd7;
               end else begin
                  shadow_free_pos = shadow_free_pos - 3'd1;
               end
            end
            if (emitted > 0) begin
               packed_bytes_due[packed_bytes_due.size() - 1].last = 1'b1;
            end
         end
         hbp_pkg::CMD_FLUSH: begin
            if (shadow_free_pos != 3'd7) begin
               pb.out_byte = shadow_byte;
               pb.last     = 1'b1;
               packed_bytes_due.push_back(pb);
            end
            shadow_byte     = '0;
            shadow_free_pos = 3'd7;
         end
         default: begin
            // The reserved command changes nothing.
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Request channel driver
   // -------------------------------------------------------------------------

   // Offers one request transaction and waits until it is accepted. The valid
   // stays high afterwards, so back to back transactions need no extra cycle;
   // at the end of a burst the sender may drop valid for a random gap.
   task automatic offer_command(input logic [CMD_W-1:0]  cmd,
                                input logic [SYM_W-1:0]  sym,
                                input logic [CODE_W-1:0] bits,
                                input logic [LEN_W-1:0]  len);
      int unsigned gap;

      req_if.valid       <= 1'b1;
      req_if.command     <= cmd;
      req_if.symbol      <= sym;
      req_if.code_bits   <= bits;
      req_if.code_length <= len;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      pack_into_bytes(cmd, sym, bits, len);

      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         // Mostly short bursts, with an occasional long stretch without gaps.
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 8);
         gap = 0;
         if (sender_gaps_on && $urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
         end
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drops valid and waits until every predicted byte has been received.
   // The loop waits for a clock edge before it checks, so valid is never lowered
   // and raised again within the same time step.
   task automatic pause_until_bytes_out();
      req_if.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (packed_bytes_due.size() != 0);
   endtask

   // Code lengths weighted toward short codes, with some long and clipped
   // lengths and some zero lengths.
   function automatic logic [LEN_W-1:0] pick_code_length();
      int unsigned r;

      r = $urandom_range(0, 99);
      if (r < 70) begin
         return LEN_W'($urandom_range(1, 10));
      end else if (r < 85) begin
         return LEN_W'($urandom_range(11, 32));
      end else if (r < 93) begin
         return LEN_W'($urandom_range(33, 63));
      end
      return '0;
   endfunction

   // -------------------------------------------------------------------------
   // Response channel receiver
   // -------------------------------------------------------------------------

   // Drives ready from a pattern that changes at random intervals. A hold
   // off request from a test overrides the pattern for a counted stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (hold_off_taken != hold_off_count) begin
            hold_off_taken = hold_off_count;
            hold_off_left  = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (rx_pattern_left == 0) begin
               rx_pattern      = rx_pattern_type'($urandom_range(0, 3));
               rx_pattern_left = $urandom_range(10, 80);
            end
            rx_pattern_left--;
            rx_phase++;
            case (rx_pattern)
               RX_ALWAYS:   rsp_if.ready <= 1'b1;
               RX_COIN:     rsp_if.ready <= 1'($urandom_range(0, 1));
               RX_PERIODIC: rsp_if.ready <= (rx_phase % 3) != 2;
               default:     rsp_if.ready <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   // Compares every accepted response transaction with the oldest predicted
   // byte. Both fields are checked separately so that each mismatch is named.
   always @(posedge clock) begin : check_bytes
      packed_byte_type want;

      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (packed_bytes_due.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual out_byte %02h last %0b",
                     $time, rsp_if.out_byte, rsp_if.last);
            mismatch_count++;
         end else begin
            want = packed_bytes_due.pop_front();
            if (rsp_if.out_byte !== want.out_byte) begin
               $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                        $time, want.out_byte, rsp_if.out_byte);
               mismatch_count++;
            end
            if (rsp_if.last !== want.last) begin
               $display("%0t: last mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_if.last);
               mismatch_count++;
            end
         end
      end
   end

   // The run ends here if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Right after reset every table entry has length zero, so encodes emit
   // nothing, and a flush of the empty packer emits nothing either.
   task automatic test_after_reset();
      offer_command(hbp_pkg::CMD_ENCODE, 8'h00, 32'h0, 6'd0);
      offer_command(hbp_pkg::CMD_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'd63);
      offer_command(hbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);
      offer_command(CMD_RESERVED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
      pause_until_bytes_out();
   endtask

   // Field extremes and the special cases: full and clipped lengths, code
   // bits above the length, zero length, a never loaded entry, flushes of a
   // partial and of an empty packer, and the reserved command.
   task automatic test_directed_corners();
      // A full 32-bit code on an empty packer gives exactly four bytes.
      offer_command(hbp_pkg::CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
      offer_command(hbp_pkg::CMD_ENCODE, 8'h00, 32'h0, 6'd0);
      // One-bit code; the high code bits must be dropped.
      offer_command(hbp_pkg::CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd1);
      offer_command(hbp_pkg::CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
      // Lengths above the table width are clipped to 32.
      offer_command(hbp_pkg::CMD_LOAD, 8'h80, 32'hA5A5_A5A5, 6'd63);
      offer_command(hbp_pkg::CMD_LOAD, 8'h01, 32'h5A5A_5A5A, 6'd33);
      offer_command(hbp_pkg::CMD_ENCODE, 8'h80, 32'h0, 6'd0);
      // Zero length with nonzero code bits emits nothing.
      offer_command(hbp_pkg::CMD_LOAD, 8'h02, 32'hDEAD_BEEF, 6'd0);
      offer_command(hbp_pkg::CMD_ENCODE, 8'h02, 32'hFFFF_FFFF, 6'd63);
      // Seven-bit code whose set bits all lie above the length.
      offer_command(hbp_pkg::CMD_LOAD, 8'h03, 32'hFFFF_FF80, 6'd7);
      offer_command(hbp_pkg::CMD_ENCODE, 8'h03, 32'h0, 6'd0);
      offer_command(hbp_pkg::CMD_ENCODE, 8'h01, 32'h0, 6'd0);
      // A partial byte is padded with zeros, then the packer is empty.
      offer_command(hbp_pkg::CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
      offer_command(hbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);
      offer_command(CMD_RESERVED, 8'h00, 32'hFFFF_FFFF, 6'd63);
      // Never loaded entry.
      offer_command(hbp_pkg::CMD_ENCODE, 8'h04, 32'h0, 6'd0);
      // Overwrite an entry with zero length.
      offer_command(hbp_pkg::CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0);
      offer_command(hbp_pkg::CMD_ENCODE, 8'h00, 32'h0, 6'd0);
      // An all-zero byte and a run of one-bit codes ending in a flush.
      offer_command(hbp_pkg::CMD_LOAD, 8'h05, 32'h0000_0000, 6'd8);
      offer_command(hbp_pkg::CMD_ENCODE, 8'h05, 32'h0, 6'd0);
      repeat (7) offer_command(hbp_pkg::CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
      offer_command(hbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);
      pause_until_bytes_out();
   endtask

   // Well-formed streams: load a random table, then encode mostly symbols
   // that were loaded, with some stray symbols, flushes, reloads and reserved
   // commands mixed in. Some phases end with a pause until all bytes are out.
   task automatic test_random_streams();
      int unsigned      sent;
      int unsigned      table_size;
      int unsigned      run_len;
      int unsigned      r;
      logic [SYM_W-1:0] loaded_syms[$];
      logic [SYM_W-1:0] sym;

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         loaded_syms.delete();
         table_size = $urandom_range(2, 24);
         for (int k = 0; k < table_size; k++) begin
            sym = SYM_W'($urandom_range(0, 255));
            offer_command(hbp_pkg::CMD_LOAD, sym, $urandom(), pick_code_length());
            loaded_syms.push_back(sym);
            sent++;
         end
         run_len = $urandom_range(10, 40);
         for (int k = 0; k < run_len; k++) begin
            r   = $urandom_range(0, 99);
            sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            if (r < 78) begin
               offer_command(hbp_pkg::CMD_ENCODE, sym, $urandom(),
                             LEN_W'($urandom_range(0, 63)));
               sent++;
            end else if (r < 86) begin
               offer_command(hbp_pkg::CMD_ENCODE, SYM_W'($urandom_range(0, 255)),
                             $urandom(), LEN_W'($urandom_range(0, 63)));
               sent++;
            end else if (r < 91) begin
               offer_command(hbp_pkg::CMD_FLUSH, SYM_W'($urandom_range(0, 255)),
                             $urandom(), LEN_W'($urandom_range(0, 63)));
               sent++;
            end else if (r < 95) begin
               offer_command(CMD_RESERVED, SYM_W'($urandom_range(0, 255)), $urandom(),
                             LEN_W'($urandom_range(0, 63)));
            end else begin
               offer_command(hbp_pkg::CMD_LOAD, sym, $urandom(), pick_code_length());
               sent++;
            end
         end
         if ($urandom_range(0, 1) == 1) begin
            offer_command(hbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);
            sent++;
         end
         if ($urandom_range(0, 3) == 0) begin
            pause_until_bytes_out();
         end
      end
      pause_until_bytes_out();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering long codes without gaps, so the block fills and stalls its
   // request channel. Afterwards the sender waits until everything drains.
   task automatic test_backpressure();
      logic [SYM_W-1:0] syms[8];

      for (int k = 0; k < 8; k++) begin
         syms[k] = SYM_W'(8'h40 + k * 23);
         offer_command(hbp_pkg::CMD_LOAD, syms[k], $urandom(),
                       LEN_W'($urandom_range(20, 32)));
      end
      sender_gaps_on = 1'b0;
      hold_off_count++;
      for (int k = 0; k < 40; k++) begin
         offer_command(hbp_pkg::CMD_ENCODE, syms[$urandom_range(0, 7)], $urandom(),
                       LEN_W'($urandom_range(0, 63)));
      end
      offer_command(hbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);
      sender_gaps_on = 1'b1;
      pause_until_bytes_out();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.command     = hbp_pkg::CMD_LOAD;
      req_if.symbol      = '0;
      req_if.code_bits   = '0;
      req_if.code_length = '0;

      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_code[i] = '0;
         shadow_len[i]  = '0;
      end
      shadow_byte     = '0;
      shadow_free_pos = 3'd7;

      burst_left     = 4;
      sender_gaps_on = 1'b1;

      // Synchronous reset, applied once at the start.
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_directed_corners();
      test_backpressure();
      test_random_streams();

      // Everything predicted has arrived; keep the clock running for a drain tail
      // so that any stray byte would still be caught by the checker.
      pause_until_bytes_out();
      repeat (DRAIN_TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
